// File: src/clcm_pkg.sv
// Package for the layer cost cell merge block.
// Holds field widths, register and mode codes, and the shared config struct.
package clcm_pkg;

  localparam int GRID_DIM = 4096;
  localparam int COORD_W  = $clog2(GRID_DIM);
  localparam int WIN_W    = COORD_W + 1;
  localparam int COST_W   = 8;
  localparam int CFG_DATA_W = 13;

  typedef enum logic [2:0] {
    REG_MERGE_MODE     = 3'd0,
    REG_LAYER_ENABLED  = 3'd1,
    REG_WINDOW_MIN_X   = 3'd2,
    REG_WINDOW_MIN_Y   = 3'd3,
    REG_WINDOW_MAX_X   = 3'd4,
    REG_WINDOW_MAX_Y   = 3'd5,
    REG_UNKNOWN_CODE   = 3'd6,
    REG_INSCRIBED_CODE = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_MAXIMUM     = 2'd0,
    MODE_TRUE_OVR    = 2'd1,
    MODE_OVR_KNOWN   = 2'd2,
    MODE_SAT_ADD     = 2'd3
  } merge_mode_t;

  typedef struct packed {
    merge_mode_t        merge_mode;
    logic               layer_enabled;
    logic [WIN_W-1:0]   window_min_x;
    logic [WIN_W-1:0]   window_min_y;
    logic [WIN_W-1:0]   window_max_x;
    logic [WIN_W-1:0]   window_max_y;
    logic [COST_W-1:0]  unknown_code;
    logic [COST_W-1:0]  inscribed_code;
  } cfg_t;

endpackage

// File: src/clcm_ifs.sv
// Channel interfaces for the layer cost cell merge block.
// Depends on clcm_pkg for field widths and the register index type.
interface clcm_cell_if;
  import clcm_pkg::*;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  cell_x;
  logic [COORD_W-1:0]  cell_y;
  logic [COST_W-1:0]   layer_cost;
  logic [COST_W-1:0]   master_cost;
  modport source (output valid, cell_x, cell_y, layer_cost, master_cost, input ready);
  modport sink   (input valid, cell_x, cell_y, layer_cost, master_cost, output ready);
endinterface

interface clcm_result_if;
  import clcm_pkg::*;
  logic               valid;
  logic               ready;
  logic [COST_W-1:0]  new_master_cost;
  logic               cell_changed;
  modport source (output valid, new_master_cost, cell_changed, input ready);
  modport sink   (input valid, new_master_cost, cell_changed, output ready);
endinterface

interface clcm_cfg_if;
  import clcm_pkg::*;
  logic                   valid;
  logic                   ready;
  reg_idx_t               index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/clcm_cfg_regs.sv
// Configuration register file of the layer cost cell merge block.
// Depends on clcm_pkg and clcm_cfg_if.
module clcm_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  clcm_cfg_if.sink           cfg,
  output clcm_pkg::cfg_t     regs
);
  import clcm_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.merge_mode     <= MODE_MAXIMUM;
      regs.layer_enabled  <= 1'b1;
      regs.window_min_x   <= '0;
      regs.window_min_y   <= '0;
      regs.window_max_x   <= '0;
      regs.window_max_y   <= '0;
      regs.unknown_code   <= COST_W'(255);
      regs.inscribed_code <= COST_W'(253);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MERGE_MODE:     regs.merge_mode     <= merge_mode_t'(cfg.data[1:0]);
        REG_LAYER_ENABLED:  regs.layer_enabled  <= cfg.data[0];
        REG_WINDOW_MIN_X:   regs.window_min_x   <= cfg.data[WIN_W-1:0];
        REG_WINDOW_MIN_Y:   regs.window_min_y   <= cfg.data[WIN_W-1:0];
        REG_WINDOW_MAX_X:   regs.window_max_x   <= cfg.data[WIN_W-1:0];
        REG_WINDOW_MAX_Y:   regs.window_max_y   <= cfg.data[WIN_W-1:0];
        REG_UNKNOWN_CODE:   regs.unknown_code   <= cfg.data[COST_W-1:0];
        REG_INSCRIBED_CODE: regs.inscribed_code <= cfg.data[COST_W-1:0];
        default: ;
      endcase
    end
  end
endmodule

// File: src/clcm_merge_pipe.sv
// Input register, merge logic and result register of the cell merge block.
// Depends on clcm_pkg, clcm_cell_if and clcm_result_if.
module clcm_merge_pipe (
  input  logic               clk,
  input  logic               rst,
  input  clcm_pkg::cfg_t     regs,
  clcm_cell_if.sink          cell_in,
  clcm_result_if.source      cell_out
);
  import clcm_pkg::*;

  logic                s1_valid;
  logic [COORD_W-1:0]  s1_x;
  logic [COORD_W-1:0]  s1_y;
  logic [COST_W-1:0]   s1_lc;
  logic [COST_W-1:0]   s1_mc;
  logic                s2_valid;
  logic [COST_W-1:0]   s2_cost;
  logic                s2_changed;

  logic                s1_ready;
  logic                s2_ready;
  logic [WIN_W-1:0]    x_ext;
  logic [WIN_W-1:0]    y_ext;
  logic                in_window;
  logic                lc_unknown;
  logic                mc_unknown;
  logic [COST_W:0]     sum;
  logic [COST_W-1:0]   cap;
  logic [COST_W-1:0]   merged;
  logic [COST_W-1:0]   result;

  assign s2_ready      = !s2_valid || cell_out.ready;
  assign s1_ready      = !s1_valid || s2_ready;
  assign cell_in.ready = s1_ready;

  assign x_ext = {1'b0, s1_x};
  assign y_ext = {1'b0, s1_y};
  assign in_window = (x_ext < WIN_W'(GRID_DIM)) && (y_ext < WIN_W'(GRID_DIM)) &&
                     (x_ext >= regs.window_min_x) && (x_ext < regs.window_max_x) &&
                     (y_ext >= regs.window_min_y) && (y_ext < regs.window_max_y);

  assign lc_unknown = (s1_lc == regs.unknown_code);
  assign mc_unknown = (s1_mc == regs.unknown_code);
  assign sum        = {1'b0, s1_mc} + {1'b0, s1_lc};
  assign cap        = (regs.inscribed_code == '0) ? '0 : regs.inscribed_code - COST_W'(1);

  always_comb begin
    case (regs.merge_mode)
      MODE_MAXIMUM: begin
        if (lc_unknown)                      merged = s1_mc;
        else if (mc_unknown || s1_mc < s1_lc) merged = s1_lc;
        else                                 merged = s1_mc;
      end
      MODE_TRUE_OVR:  merged = s1_lc;
      MODE_OVR_KNOWN: merged = lc_unknown ? s1_mc : s1_lc;
      MODE_SAT_ADD: begin
        if (lc_unknown)                               merged = s1_mc;
        else if (mc_unknown)                          merged = s1_lc;
        else if (sum >= {1'b0, regs.inscribed_code}) merged = cap;
        else                                          merged = sum[COST_W-1:0];
      end
      default: merged = s1_mc;
    endcase
  end

  assign result = (regs.layer_enabled && in_window) ? merged : s1_mc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= cell_in.valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_in.valid && s1_ready) begin
      s1_x  <= cell_in.cell_x;
      s1_y  <= cell_in.cell_y;
      s1_lc <= cell_in.layer_cost;
      s1_mc <= cell_in.master_cost;
    end
    if (s1_valid && s2_ready) begin
      s2_cost    <= result;
      s2_changed <= (result != s1_mc);
    end
  end

  assign cell_out.valid           = s2_valid;
  assign cell_out.new_master_cost = s2_cost;
  assign cell_out.cell_changed    = s2_changed;
endmodule

// File: src/cost_layer_cell_merge_core.sv
// Top level of the layer cost cell merge block.
// Depends on clcm_pkg, the channel interfaces, clcm_cfg_regs and clcm_merge_pipe.
//
//   channel   | dir | fields
//   cell_in   | in  | cell_x, cell_y, layer_cost, master_cost
//   cell_out  | out | new_master_cost, cell_changed
//   cfg       | in  | index, data (always ready)
//
// One word per cycle sustained while cell_out does not stall; a word
// passes the input register, then the result register after compare/add/select.
// Reset clears both stage valids and loads the register reset values.
// A stall at cell_out holds the result; cell_in still takes a word
// while the input register is free.
module cost_layer_cell_merge_core (
  input  logic           clk,
  input  logic           rst,
  clcm_cell_if.sink      cell_in,
  clcm_result_if.source  cell_out,
  clcm_cfg_if.sink       cfg
);
  import clcm_pkg::*;

  cfg_t regs;

  clcm_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  clcm_merge_pipe u_merge_pipe (
    .clk      (clk),
    .rst      (rst),
    .regs     (regs),
    .cell_in  (cell_in),
    .cell_out (cell_out)
  );
endmodule

// File: src/clcm_checker.sv
// Port-level checks for the layer cost cell merge block.
// Depends on clcm_pkg; bound to cost_layer_cell_merge_core.
module clcm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [clcm_pkg::COST_W-1:0] out_cost,
  input logic                       out_changed
);
  import clcm_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready |=> out_valid)
    else $error("accepted word missing at output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_cost) && $stable(out_changed))
    else $error("stalled result changed");
endmodule

bind cost_layer_cell_merge_core clcm_checker u_clcm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (cell_in.valid),
  .in_ready    (cell_in.ready),
  .out_valid   (cell_out.valid),
  .out_ready   (cell_out.ready),
  .out_cost    (cell_out.new_master_cost),
  .out_changed (cell_out.cell_changed)
);
